/* hw/rtl/sida_pkg.sv */
`timescale 1ns / 1ps

package sida_pkg;

   localparam int DEFAULT_VALUE_WIDTH = 32;

   localparam logic [7:0] ASCII_ZERO  = 8'h30;
   localparam logic [7:0] ASCII_MINUS = 8'h2D;

   localparam logic [3:0] DIGIT_ADJUST_MIN = 4'd5;
   localparam logic [3:0] DIGIT_ADJUST_ADD = 4'd3;

   // status handed from the converter to the emitter
   typedef struct packed {
      logic done;       // one-cycle pulse: BCD word is complete
      logic negative;   // sign of the request being converted
   } conv_status_type;

   // shift-and-add-3 correction of one BCD digit
   function automatic logic [3:0] dabble_adjust(input logic [3:0] digit);
      logic [3:0] result;
      if (digit >= DIGIT_ADJUST_MIN) begin
         result = digit + DIGIT_ADJUST_ADD;
      end else begin
         result = digit;
      end
      return result;
   endfunction

endpackage

/* hw/rtl/sida_if.sv */
`timescale 1ns / 1ps

interface sida_req_if #(
   parameter int VALUE_WIDTH = sida_pkg::DEFAULT_VALUE_WIDTH
);
   logic                   valid;
   logic                   ready;
   logic [VALUE_WIDTH-1:0] value;

   modport source (output valid, output value, input ready);
   modport sink   (input valid, input value, output ready);
endinterface

interface sida_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] character;
   logic       last;

   modport source (output valid, output character, output last, input ready);
   modport sink   (input valid, input character, input last, output ready);
endinterface

/* hw/rtl/sida_dabble.sv */
`timescale 1ns / 1ps

module sida_dabble #(
   parameter int VALUE_WIDTH = sida_pkg::DEFAULT_VALUE_WIDTH,
   parameter int DIGITS      = 10
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [VALUE_WIDTH-1:0]       value,
   output logic                         busy,
   output logic [4*DIGITS-1:0]          bcd,
   output sida_pkg::conv_status_type    status
);

   localparam int COUNT_W = $clog2(VALUE_WIDTH + 1);

   logic [COUNT_W-1:0]     count_ff, count_in;
   logic [VALUE_WIDTH-1:0] bin_ff, bin_in;
   logic [4*DIGITS-1:0]    bcd_ff, bcd_in;
   logic                   neg_ff, neg_in;
   logic                   done_ff, done_in;
   logic [4*DIGITS-1:0]    adjusted;

   // every digit corrected in parallel, then one binary bit shifted in
   always_comb begin
      for (int i = 0; i < DIGITS; i++) begin
         adjusted[4*i +: 4] = sida_pkg::dabble_adjust(bcd_ff[4*i +: 4]);
      end
   end

   always_comb begin
      count_in = count_ff;
      bin_in   = bin_ff;
      bcd_in   = bcd_ff;
      neg_in   = neg_ff;
      done_in  = 1'b0;
      if (start) begin
         neg_in   = value[VALUE_WIDTH-1];
         bin_in   = value[VALUE_WIDTH-1] ? (~value + 1'b1) : value;
         bcd_in   = '0;
         count_in = COUNT_W'(VALUE_WIDTH);
      end else if (count_ff != '0) begin
         bcd_in   = {adjusted[4*DIGITS-2:0], bin_ff[VALUE_WIDTH-1]};
         bin_in   = {bin_ff[VALUE_WIDTH-2:0], 1'b0};
         count_in = count_ff - 1'b1;
         done_in  = (count_ff == COUNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         done_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         done_ff  <= done_in;
      end
      bin_ff <= bin_in;
      bcd_ff <= bcd_in;
      neg_ff <= neg_in;
   end

   assign busy            = (count_ff != '0) || done_ff;
   assign bcd             = bcd_ff;
   assign status.done     = done_ff;
   assign status.negative = neg_ff;

endmodule

/* hw/rtl/sida_emit.sv */
`timescale 1ns / 1ps

module sida_emit #(
   parameter int DIGITS = 10
) (
   input  logic                      clock,
   input  logic                      reset,
   input  sida_pkg::conv_status_type status,
   input  logic [4*DIGITS-1:0]       bcd,
   output logic                      busy,
   sida_rsp_if.source                rsp_bus
);

   localparam int LEFT_W = $clog2(DIGITS + 1);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SKIP = 2'd1;
   localparam logic [1:0] ST_SIGN = 2'd2;
   localparam logic [1:0] ST_EMIT = 2'd3;

   logic [1:0]          state_ff, state_in;
   logic [LEFT_W-1:0]   left_ff, left_in;
   logic [4*DIGITS-1:0] bcd_ff, bcd_in;
   logic                neg_ff, neg_in;
   logic [3:0]          top_digit;
   logic                final_digit;

   assign top_digit   = bcd_ff[4*DIGITS-1 -: 4];
   assign final_digit = (left_ff == LEFT_W'(1));

   always_comb begin
      state_in = state_ff;
      left_in  = left_ff;
      bcd_in   = bcd_ff;
      neg_in   = neg_ff;
      case (state_ff)
         ST_IDLE: begin
            if (status.done) begin
               bcd_in   = bcd;
               neg_in   = status.negative;
               left_in  = LEFT_W'(DIGITS);
               state_in = ST_SKIP;
            end
         end
         ST_SKIP: begin
            // drop leading zeros, keeping at least one digit
            if (top_digit == 4'd0 && !final_digit) begin
               bcd_in  = {bcd_ff[4*DIGITS-5:0], 4'd0};
               left_in = left_ff - 1'b1;
            end else begin
               state_in = neg_ff ? ST_SIGN : ST_EMIT;
            end
         end
         ST_SIGN: begin
            if (rsp_bus.ready) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (rsp_bus.ready) begin
               bcd_in  = {bcd_ff[4*DIGITS-5:0], 4'd0};
               left_in = left_ff - 1'b1;
               if (final_digit) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      left_ff <= left_in;
      bcd_ff  <= bcd_in;
      neg_ff  <= neg_in;
   end

   assign busy              = (state_ff != ST_IDLE);
   assign rsp_bus.valid     = (state_ff == ST_SIGN) || (state_ff == ST_EMIT);
   assign rsp_bus.character = (state_ff == ST_SIGN) ? sida_pkg::ASCII_MINUS
                                                    : (sida_pkg::ASCII_ZERO | {4'd0, top_digit});
   assign rsp_bus.last      = (state_ff == ST_EMIT) && final_digit;

endmodule

/* hw/rtl/signed_int_to_decimal_ascii.sv */
`timescale 1ns / 1ps

// Signed integer to decimal ASCII. Each request carries one two's complement
// value of VALUE_WIDTH bits; the block answers with its decimal text, one
// character per response, most significant first: a leading '-' for a
// negative value, then the digits with no leading zeros (zero gives "0"),
// the final character flagged by last. The most negative value converts
// correctly through its unsigned magnitude. One request is in flight at a
// time: req_bus.ready is low from acceptance until the last character has
// been taken. Each request passes through bit-serial shift-and-add-3
// conversion (one magnitude bit per cycle), a hand-over of the BCD word to
// the emitter, a strip stage that drops leading zero digits one at a time,
// and the emission of one character per response. With the response side
// always ready, the serial binary-to-BCD shift register sets most of the
// time per request.

module signed_int_to_decimal_ascii #(
   parameter int VALUE_WIDTH = sida_pkg::DEFAULT_VALUE_WIDTH
) (
   input  logic     clock,
   input  logic     reset,
   sida_req_if.sink   req_bus,
   sida_rsp_if.source rsp_bus
);

   // digits of the largest magnitude, 2^(VALUE_WIDTH-1)
   localparam int DIGITS = ((VALUE_WIDTH - 1) * 30103) / 100000 + 1;

   logic                      conv_busy;
   logic                      emit_busy;
   logic                      start;
   logic [4*DIGITS-1:0]       bcd;
   sida_pkg::conv_status_type status;

   // take a new request only when both stages are empty
   assign req_bus.ready = !conv_busy && !emit_busy;
   assign start         = req_bus.valid && req_bus.ready;

   // binary magnitude to packed BCD, one bit per cycle
   sida_dabble #(
      .VALUE_WIDTH (VALUE_WIDTH),
      .DIGITS      (DIGITS)
   ) u_dabble (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .value  (req_bus.value),
      .busy   (conv_busy),
      .bcd    (bcd),
      .status (status)
   );

   // zero strip, sign, then one character per response
   sida_emit #(
      .DIGITS (DIGITS)
   ) u_emit (
      .clock   (clock),
      .reset   (reset),
      .status  (status),
      .bcd     (bcd),
      .busy    (emit_busy),
      .rsp_bus (rsp_bus)
   );

endmodule

/* tb/sv/sida_text_monitor.sv */
`timescale 1ns / 1ps

module sida_text_monitor #(
   parameter int VALUE_WIDTH = sida_pkg::DEFAULT_VALUE_WIDTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_ready,
   input  logic [VALUE_WIDTH-1:0] req_value,
   input  logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  logic [7:0]             rsp_character,
   input  logic                   rsp_last,
   output int                     error_count,
   output int                     pending_chars,
   output int                     request_count,
   output int                     negative_count,
   output int                     char_count
);

   localparam int RADIX       = 10;
   localparam int DIGIT_SLOTS = 24;
   localparam int SHOWN_LIMIT = 10;

   typedef struct {
      logic [7:0] character;
      logic       last;
   } text_char_type;

   text_char_type expected_text[$];

   // decimal text of one request, pushed in emission order
   function automatic void queue_decimal_text(input logic [VALUE_WIDTH-1:0] value);
      logic [VALUE_WIDTH:0] magnitude;
      logic [3:0]           digits[DIGIT_SLOTS];
      int                   digit_total;
      int                   i;
      logic                 negative;
      text_char_type        text_char;
      negative    = value[VALUE_WIDTH-1];
      // one bit wider, so the most negative value has room
      magnitude   = negative ? ({1'b0, ~value} + 1'b1) : {1'b0, value};
      digit_total = 0;
      do begin
         digits[digit_total] = 4'(magnitude % RADIX);
         magnitude           = magnitude / RADIX;
         digit_total++;
      end while (magnitude != 0 && digit_total < DIGIT_SLOTS);
      if (negative) begin
         text_char.character = sida_pkg::ASCII_MINUS;
         text_char.last      = 1'b0;
         expected_text.push_back(text_char);
      end
      for (i = digit_total - 1; i >= 0; i--) begin
         text_char.character = sida_pkg::ASCII_ZERO + {4'd0, digits[i]};
         text_char.last      = (i == 0);
         expected_text.push_back(text_char);
      end
   endfunction

   always @(posedge clock) begin
      text_char_type want;
      if (reset) begin
         expected_text.delete();
         error_count    = 0;
         request_count  = 0;
         negative_count = 0;
         char_count     = 0;
      end else begin
         if (req_valid && req_ready) begin
            queue_decimal_text(req_value);
            request_count++;
            if (req_value[VALUE_WIDTH-1]) begin
               negative_count++;
            end
         end
         if (rsp_valid && rsp_ready) begin
            char_count++;
            if (expected_text.size() == 0) begin
               error_count++;
               if (error_count <= SHOWN_LIMIT) begin
                  $display("%0t: unexpected character 0x%02h last=%0b",
                           $realtime, rsp_character, rsp_last);
               end
            end else begin
               want = expected_text.pop_front();
               if (rsp_character !== want.character || rsp_last !== want.last) begin
                  error_count++;
                  if (error_count <= SHOWN_LIMIT) begin
                     $display("%0t: mismatch: expected 0x%02h last=%0b, got 0x%02h last=%0b",
                              $realtime, want.character, want.last,
                              rsp_character, rsp_last);
                  end
               end
            end
         end
      end
      pending_chars = expected_text.size();
   end

endmodule

/* tb/sv/tb_signed_int_to_decimal_ascii.sv */
`timescale 1ns / 1ps

// Top of the testbench: clock, reset, request stimulus, response ready
// pattern and the verdict. All prediction and comparison live in the monitor.

module tb_signed_int_to_decimal_ascii;

   localparam int WIDTH        = sida_pkg::DEFAULT_VALUE_WIDTH;
   localparam int RESET_CYCLES = 7;
   localparam int MAX_WAIT     = 10;     // longest random gap or stall per item
   localparam int RANDOM_ITEMS = 305;
   localparam int HOLD_AT      = 60;     // random item at which responses are held
   localparam int PAUSE_AT     = 150;    // random item at which the sender drains
   localparam int HOLD_CYCLES  = 400;    // long response back-pressure stretch
   localparam int DRAIN_CYCLES = 80;     // settling time once nothing is pending
   // Worst request: the conversion, 11 characters each stalled up to MAX_WAIT,
   // plus a sender gap; then the long HOLD_CYCLES hold. Ample margin on both.
   localparam int IDLE_LIMIT   = 2000;

   logic clock;
   logic reset;

   sida_req_if #(.VALUE_WIDTH(WIDTH)) req_bus ();
   sida_rsp_if                        rsp_bus ();

   int error_count;
   int pending_chars;
   int request_count;
   int negative_count;
   int char_count;

   // sender and receiver idling ceilings; zero gives stretches with no idling
   int  req_gap_ceiling;
   int  rsp_stall_ceiling;
   // set by the sender, taken by the receiver: hold ready low for a long stretch
   bit  rsp_hold_wanted;
   int  idle_cycles;

   signed_int_to_decimal_ascii #(
      .VALUE_WIDTH(WIDTH)
   ) DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   sida_text_monitor #(
      .VALUE_WIDTH(WIDTH)
   ) u_text_monitor (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_bus.valid),
      .req_ready      (req_bus.ready),
      .req_value      (req_bus.value),
      .rsp_valid      (rsp_bus.valid),
      .rsp_ready      (rsp_bus.ready),
      .rsp_character  (rsp_bus.character),
      .rsp_last       (rsp_bus.last),
      .error_count    (error_count),
      .pending_chars  (pending_chars),
      .request_count  (request_count),
      .negative_count (negative_count),
      .char_count     (char_count)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Offer one request after a random gap and hold it until accepted. With no
   // gap, valid stays high from the previous request: no low-high in one step.
   task automatic send_value(input logic [WIDTH-1:0] value);
      int gap;
      gap = $urandom_range(req_gap_ceiling, 0);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.value <= value;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   // Mid-cycle look at the monitor's backlog; back on the rising edge after.
   task automatic wait_text_drained();
      do @(negedge clock); while (pending_chars != 0);
      @(posedge clock);
   endtask

   // Mostly values of a random digit count and sign, so short and long texts
   // are both common; some raw words for bit coverage, some range extremes.
   function automatic logic [WIDTH-1:0] random_value();
      int                 pick;
      int                 digit_total;
      int                 k;
      longint             low;
      longint             high;
      logic [WIDTH-1:0]   magnitude;
      logic [WIDTH-1:0]   value;
      pick = $urandom_range(99, 0);
      if (pick < 15) begin
         value = $urandom;
      end else if (pick < 22) begin
         case ($urandom_range(5, 0))
            0:       value = '0;
            1:       value = 32'h7FFF_FFFF;
            2:       value = 32'h8000_0000;
            3:       value = 32'h8000_0001;
            4:       value = 32'hFFFF_FFFF;
            default: value = 32'h0000_0001;
         endcase
      end else begin
         digit_total = $urandom_range(10, 1);
         high = 1;
         for (k = 0; k < digit_total; k++) begin
            high = high * 10;
         end
         low  = (digit_total == 1) ? 0 : high / 10;
         high = high - 1;
         if (high > 64'sd2147483647) begin
            high = 64'sd2147483647;
         end
         magnitude = $urandom_range(32'(high), 32'(low));
         value     = $urandom_range(1, 0) ? -magnitude : magnitude;
      end
      return value;
   endfunction

   // request side and verdict
   initial begin
      int i;
      reset             = 1'b1;
      req_bus.valid     = 1'b0;
      req_bus.value     = '0;
      req_gap_ceiling   = MAX_WAIT;
      rsp_hold_wanted   = 1'b0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: zero, single digits, decade boundaries, both range ends
      send_value(0);
      send_value(1);
      send_value(-1);
      send_value(9);
      send_value(-9);
      send_value(10);
      send_value(-10);
      send_value(99);
      send_value(100);
      send_value(-100);
      send_value(12345);
      send_value(-67890);
      send_value(999999999);
      send_value(-999999999);
      send_value(1000000000);
      send_value(-1000000000);
      send_value(2147483647);
      send_value(-2147483647);
      send_value(32'h8000_0000);   // most negative: magnitude needs the extra bit
      send_value(32'h5555_5555);
      send_value(32'hAAAA_AAAA);
      send_value(0);

      for (i = 0; i < RANDOM_ITEMS; i++) begin
         if (i % 40 == 0) begin
            req_gap_ceiling = ($urandom_range(3, 0) == 0) ? 0 : MAX_WAIT;
         end
         if (i == HOLD_AT) begin
            rsp_hold_wanted = 1'b1;
         end
         if (i == PAUSE_AT) begin
            req_bus.valid <= 1'b0;
            wait_text_drained();
         end
         send_value(random_value());
      end
      req_bus.valid <= 1'b0;

      wait_text_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Converted %0d requests (%0d negative) into %0d characters,",
               request_count, negative_count, char_count);
      $display("with random gaps, a %0d-cycle response hold and a full drain mid-run.",
               HOLD_CYCLES);
      if (error_count == 0 && pending_chars == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   // response side: random stall before each character, or the long hold
   initial begin
      int stall;
      int served;
      rsp_bus.ready     = 1'b0;
      rsp_stall_ceiling = MAX_WAIT;
      served            = 0;
      do @(posedge clock); while (reset);
      forever begin
         if (served % 50 == 0) begin
            rsp_stall_ceiling = ($urandom_range(3, 0) == 0) ? 0 : MAX_WAIT;
         end
         if (rsp_hold_wanted) begin
            rsp_hold_wanted = 1'b0;
            stall = HOLD_CYCLES;
         end else begin
            stall = $urandom_range(rsp_stall_ceiling, 0);
         end
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!rsp_bus.valid);
         served++;
      end
   end

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (!reset && idle_cycles >= IDLE_LIMIT) begin
         $display("Timeout: no handshake for %0d cycles", IDLE_LIMIT);
         $display("CHECK FAILED");
         $finish;
      end
   end

endmodule
